[src/hill_cipher_3x3_mod26_defines.svh]
// Assertion macros for the Hill cipher block.
// Depends on nothing; included by the top level, which holds the assertions.
`ifndef HILL_CIPHER_3X3_MOD26_DEFINES_SVH
`define HILL_CIPHER_3X3_MOD26_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define HC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hill cipher check failed");
// Next-cycle implication, disabled during reset.
`define HC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hill cipher check failed");
`else
`define HC_ASSERT_NOW(label, clk, rst, ante, cons)
`define HC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[src/hc_pkg.sv]
// Shared types, constants and modulo-26 helpers for the Hill cipher block.
// Used by hc_keyprep, hc_datapath and hill_cipher_3x3_mod26; depends on nothing.
package hc_pkg;

  localparam int BLOCK_SIZE_DEF = 3;
  localparam int KEY_W          = 45;
  localparam int LETTER_W       = 5;
  localparam int PDATA_W        = 64;
  localparam int PADDR_W        = 4;
  localparam int KEY_LAT        = 7;   // register stages in the key preparation pipeline

  // Register index decoded from paddr[PADDR_W-1:3].
  localparam logic [PADDR_W-4:0] REG_KEY = '0;

  localparam logic [4:0]  MODULUS   = 5'd26;
  // floor(2^16 / 26) + 1; exact quotient for any value below 2048.
  localparam logic [23:0] MOD_RECIP = 24'd2521;

  typedef logic [2:0][2:0][LETTER_W-1:0] mat_t;

  typedef struct packed {
    logic                req_type;
    logic [LETTER_W-1:0] letter_a;
    logic [LETTER_W-1:0] letter_b;
    logic [LETTER_W-1:0] letter_c;
  } in_item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] out_a;
    logic [LETTER_W-1:0] out_b;
    logic [LETTER_W-1:0] out_c;
    logic                status;
  } out_item_t;

  typedef struct packed {
    mat_t enc;     // reduced key, entries outside the block zeroed
    mat_t dec;     // inverse key, entries outside the block zeroed
    logic ok;      // determinant is a unit modulo 26
    logic ready;   // matrices reflect the current key register
  } key_info_t;

  // Reduce a 5-bit value to 0..25.
  function automatic logic [4:0] red26(input logic [4:0] x);
    return (x >= MODULUS) ? x - MODULUS : x;
  endfunction

  // Remainder modulo 26 of an 11-bit value through a reciprocal multiply.
  function automatic logic [4:0] mod26(input logic [10:0] x);
    logic [23:0] prod;
    logic [6:0]  q;
    logic [10:0] r;
    prod = 24'(x) * MOD_RECIP;
    q    = prod[22:16];
    r    = x - 11'(q) * 11'(MODULUS);
    return r[4:0];
  endfunction

  // a - b modulo 26, both in 0..25.
  function automatic logic [4:0] sub26(input logic [4:0] a, input logic [4:0] b);
    return (a >= b) ? a - b : a + MODULUS - b;
  endfunction

  // -a modulo 26, a in 0..25.
  function automatic logic [4:0] neg26(input logic [4:0] a);
    return (a == 5'd0) ? 5'd0 : MODULUS - a;
  endfunction

  // Multiplicative inverse modulo 26; zero when none exists.
  function automatic logic [4:0] inv26(input logic [4:0] d);
    logic [4:0] r;
    case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

[src/hc_keyprep.sv]
// Key preparation pipeline: reduced key, cofactors, determinant and inverse key.
// Depends on hc_pkg.
module hc_keyprep #(
  parameter int BLOCK_SIZE = hc_pkg::BLOCK_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [hc_pkg::KEY_W-1:0] key,
  input  logic                     load,
  output hc_pkg::key_info_t        info
);

  localparam int CNT_W = $clog2(hc_pkg::KEY_LAT + 1);

  logic [CNT_W-1:0] cnt;

  hc_pkg::mat_t m1, m2, m3, m4, m5, m6, enc7, dec7, cof3, cof4, cof5, cof_c;
  logic [2:0][2:0][9:0] pa2, pb2, ip6;
  logic [2:0][9:0]      dp4;
  logic [4:0]           dinv5;
  logic                 ok7;

  // The stages run freely on the static key; the counter marks the settling time.
  always_ff @(posedge clk) begin
    if (rst || load) begin
      cnt <= CNT_W'(hc_pkg::KEY_LAT);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (r < BLOCK_SIZE && c < BLOCK_SIZE) begin
          m1[r][c] <= hc_pkg::red26(key[5*(3*r+c) +: 5]);
        end else begin
          m1[r][c] <= '0;
        end
      end
    end
  end

  // Two-by-two minor products for every entry.
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pa2[r][c] <= 10'(m1[(r == 0) ? 1 : 0][(c == 0) ? 1 : 0])
                   * 10'(m1[(r == 2) ? 1 : 2][(c == 2) ? 1 : 2]);
        pb2[r][c] <= 10'(m1[(r == 0) ? 1 : 0][(c == 2) ? 1 : 2])
                   * 10'(m1[(r == 2) ? 1 : 2][(c == 0) ? 1 : 0]);
      end
    end
    m2 <= m1;
  end

  generate
    if (BLOCK_SIZE == 3) begin : g_cof3
      always_comb begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            if (((r + c) % 2) == 1) begin
              cof_c[r][c] = hc_pkg::neg26(hc_pkg::sub26(hc_pkg::mod26(11'(pa2[r][c])),
                                                        hc_pkg::mod26(11'(pb2[r][c]))));
            end else begin
              cof_c[r][c] = hc_pkg::sub26(hc_pkg::mod26(11'(pa2[r][c])),
                                          hc_pkg::mod26(11'(pb2[r][c])));
            end
          end
        end
      end
    end else begin : g_cof2
      // With a two-letter block each cofactor is a single signed entry.
      always_comb begin
        cof_c       = '0;
        cof_c[0][0] = m2[1][1];
        cof_c[0][1] = hc_pkg::neg26(m2[1][0]);
        cof_c[1][0] = hc_pkg::neg26(m2[0][1]);
        cof_c[1][1] = m2[0][0];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    cof3 <= cof_c;
    m3   <= m2;
  end

  // Determinant by expansion along the first row.
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      dp4[j] <= 10'(m3[0][j]) * 10'(cof3[0][j]);
    end
    cof4 <= cof3;
    m4   <= m3;
  end

  always_ff @(posedge clk) begin
    dinv5 <= hc_pkg::inv26(hc_pkg::mod26(11'(dp4[0]) + 11'(dp4[1]) + 11'(dp4[2])));
    cof5  <= cof4;
    m5    <= m4;
  end

  // The inverse is the transposed cofactor matrix scaled by the determinant's inverse.
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ip6[r][c] <= 10'(cof5[c][r]) * 10'(dinv5);
      end
    end
    ok7 <= (dinv5 != 5'd0);
    m6  <= m5;
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (r < BLOCK_SIZE && c < BLOCK_SIZE) begin
          dec7[r][c] <= hc_pkg::mod26(11'(ip6[r][c]));
        end else begin
          dec7[r][c] <= '0;
        end
      end
    end
    enc7 <= m6;
  end

  assign info.enc   = enc7;
  assign info.dec   = dec7;
  assign info.ok    = ok7;
  assign info.ready = (cnt == '0);

endmodule

[src/hc_datapath.sv]
// Four-stage letter pipeline: reduce, multiply, sum, reduce modulo 26.
// Depends on hc_pkg; matrices come from hc_keyprep.
module hc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  hc_pkg::in_item_t    in_item,
  input  hc_pkg::key_info_t   info,
  output logic                out_valid,
  input  logic                out_stall,
  output hc_pkg::out_item_t   out_item
);

  logic v1, v2, v3, v4;
  logic mv1, mv2, mv3, mv4;

  logic                 req1;
  logic [2:0][4:0]      blk1;
  logic [2:0][2:0][9:0] prod2;
  logic [2:0][10:0]     acc3;
  hc_pkg::mat_t         use_m;

  // A stage takes new data when it is empty or its contents move on.
  assign mv4 = !v4 || !out_stall;
  assign mv3 = !v3 || mv4;
  assign mv2 = !v2 || mv3;
  assign mv1 = !v1 || mv2;
  assign in_stall = !mv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (mv1) v1 <= in_valid;
      if (mv2) v2 <= v1;
      if (mv3) v3 <= v2;
      if (mv4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      req1    <= in_item.req_type;
      blk1[0] <= hc_pkg::red26(in_item.letter_a);
      blk1[1] <= hc_pkg::red26(in_item.letter_b);
      blk1[2] <= hc_pkg::red26(in_item.letter_c);
    end
  end

  assign use_m = req1 ? info.dec : info.enc;

  always_ff @(posedge clk) begin
    if (mv2) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod2[i][j] <= 10'(use_m[i][j]) * 10'(blk1[j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv3) begin
      for (int i = 0; i < 3; i++) begin
        acc3[i] <= 11'(prod2[i][0]) + 11'(prod2[i][1]) + 11'(prod2[i][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv4) begin
      if (info.ok) begin
        out_item.out_a  <= hc_pkg::mod26(acc3[0]);
        out_item.out_b  <= hc_pkg::mod26(acc3[1]);
        out_item.out_c  <= hc_pkg::mod26(acc3[2]);
        out_item.status <= 1'b0;
      end else begin
        out_item.out_a  <= '0;
        out_item.out_b  <= '0;
        out_item.out_c  <= '0;
        out_item.status <= 1'b1;
      end
    end
  end

  assign out_valid = v4;

endmodule

[src/hill_cipher_3x3_mod26.sv]
// Top level of the 3x3 Hill cipher modulo 26: key register, key preparation, letter pipeline.
// Depends on hc_pkg, hc_keyprep, hc_datapath and hill_cipher_3x3_mod26_defines.svh.
//
//   Channel   Signals                          Direction  Transaction
//   blk       blk_valid, blk_stall, blk_data   in         one letter block and request
//   res       res_valid, res_stall, res_data   out        three result letters and status
//   config    psel/penable/pwrite/paddr/...    in         45-bit key register at byte 0
//
// One block enters per cycle while blk_stall is low; each result is formed in turn by the four
// register stages of the letter pipeline (reduce, multiply, sum, mod 26).
// After reset and after every key write, blk_stall stays high while the key preparation
// pipeline derives the inverse key and the determinant check.
// A stall on res holds the output register and every stage directly behind it that is
// occupied; an empty stage still takes data, so bubbles are squeezed out and the stall
// reaches blk_stall only once all four stages hold a transaction.
`include "hill_cipher_3x3_mod26_defines.svh"

module hill_cipher_3x3_mod26 #(
  parameter int BLOCK_SIZE = hc_pkg::BLOCK_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hc_pkg::PADDR_W-1:0] paddr,
  input  logic [hc_pkg::PDATA_W-1:0] pwdata,
  output logic [hc_pkg::PDATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       blk_valid,
  output logic                       blk_stall,
  input  hc_pkg::in_item_t           blk_data,
  output logic                       res_valid,
  input  logic                       res_stall,
  output hc_pkg::out_item_t          res_data
);

  logic [hc_pkg::KEY_W-1:0] key_matrix;
  logic                     key_wr;
  logic                     dp_stall;
  hc_pkg::key_info_t        info;

  // The bus never waits. Registers are decoded on the 8-byte word index, so an
  // address outside the register list is accepted and dropped.
  assign pready = 1'b1;
  assign key_wr = psel && penable && pwrite && pready
                  && (paddr[hc_pkg::PADDR_W-1:3] == hc_pkg::REG_KEY);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_matrix <= '0;
    end else if (key_wr) begin
      key_matrix <= pwdata[hc_pkg::KEY_W-1:0];
    end
  end

  // Reads return the key register at its word and zero elsewhere.
  always_comb begin
    if (paddr[hc_pkg::PADDR_W-1:3] == hc_pkg::REG_KEY) begin
      prdata = hc_pkg::PDATA_W'(key_matrix);
    end else begin
      prdata = '0;
    end
  end

  // The key preparation restarts on every key write and after reset.
  hc_keyprep #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_keyprep (
    .clk  (clk),
    .rst  (rst),
    .key  (key_matrix),
    .load (key_wr),
    .info (info)
  );

  // Blocks are held off until the derived matrices match the key register.
  hc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (blk_valid && info.ready),
    .in_stall  (dp_stall),
    .in_item   (blk_data),
    .info      (info),
    .out_valid (res_valid),
    .out_stall (res_stall),
    .out_item  (res_data)
  );

  assign blk_stall = dp_stall || !info.ready;

  // No block may enter while the key matrices are still settling.
  `HC_ASSERT_NOW(a_stall_while_settling, clk, rst, !info.ready, blk_stall)
  // A key write holds off the input channel in the following cycle.
  `HC_ASSERT_NEXT(a_stall_after_write, clk, rst, key_wr, blk_stall)
  // An error result carries zero letters.
  `HC_ASSERT_NOW(a_error_zero_letters, clk, rst, res_valid && res_data.status,
                 res_data.out_a == '0 && res_data.out_b == '0 && res_data.out_c == '0)

endmodule

[tb/hc_tb_pkg.sv]
// Request and status codes, register address and modulo-26 matrix helpers for the
// Hill cipher testbench. Depends on hc_pkg for the widths of the block.
package hc_tb_pkg;

  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_NO_INVERSE = 1'b1;

  // The key register is register zero, so it sits at byte address zero.
  localparam logic [hc_pkg::PADDR_W-1:0] KEY_ADDR = '0;

  localparam int ALPHABET = 26;

  typedef logic [2:0][2:0][4:0] key_grid_t;

  function automatic int mod_alpha(input int x);
    int r;
    r = x % ALPHABET;
    return (r < 0) ? r + ALPHABET : r;
  endfunction

  // Row-major unpacking with every entry reduced to 0..25.
  function automatic key_grid_t unpack_key(input logic [hc_pkg::KEY_W-1:0] key);
    key_grid_t m;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        m[r][c] = 5'(mod_alpha(int'(key[5*(3*r+c) +: 5])));
    return m;
  endfunction

  // Signed cofactor of a 3x3 matrix; the cyclic index form carries the sign.
  function automatic int grid_cofactor(input key_grid_t m, input int r, input int c);
    return int'(m[(r+1)%3][(c+1)%3]) * int'(m[(r+2)%3][(c+2)%3])
         - int'(m[(r+1)%3][(c+2)%3]) * int'(m[(r+2)%3][(c+1)%3]);
  endfunction

  function automatic int grid_det(input key_grid_t m);
    int acc;
    acc = 0;
    for (int c = 0; c < 3; c++)
      acc += int'(m[0][c]) * grid_cofactor(m, 0, c);
    return mod_alpha(acc);
  endfunction

  // Zero when the determinant has no inverse modulo 26.
  function automatic int unit_inverse(input int d);
    for (int i = 1; i < ALPHABET; i++)
      if ((i * d) % ALPHABET == 1)
        return i;
    return 0;
  endfunction

endpackage

[tb/hill_cipher_3x3_mod26_checker.sv]
// Scoreboard for the Hill cipher block: tracks the key register, predicts each block
// and compares results in order. Depends on hc_pkg and hc_tb_pkg.
module hill_cipher_3x3_mod26_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [hc_pkg::PADDR_W-1:0] paddr,
  input  logic [hc_pkg::PDATA_W-1:0] pwdata,
  input  logic                       blk_valid,
  input  logic                       blk_stall,
  input  hc_pkg::in_item_t           blk_data,
  input  logic                       res_valid,
  input  logic                       res_stall,
  input  hc_pkg::out_item_t          res_data,
  output int                         fail_count,
  output int                         outstanding,
  output int                         checked,
  output int                         refused
);
  timeunit 1ns;
  timeprecision 1ps;

  import hc_pkg::*;
  import hc_tb_pkg::*;

  logic [KEY_W-1:0] key_copy = '0;
  out_item_t        pending_results [$];

  function automatic out_item_t cipher_block(input logic [KEY_W-1:0] key, input in_item_t blk);
    key_grid_t k;
    key_grid_t m;
    int        v [3];
    int        res [3];
    int        dinv;
    out_item_t r;
    k = unpack_key(key);
    v[0] = mod_alpha(int'(blk.letter_a));
    v[1] = mod_alpha(int'(blk.letter_b));
    v[2] = mod_alpha(int'(blk.letter_c));
    dinv = unit_inverse(grid_det(k));
    r = '0;
    if (dinv == 0) begin
      r.status = STATUS_NO_INVERSE;
      return r;
    end
    m = k;
    if (blk.req_type == REQ_DECRYPT) begin
      // Inverse key: transposed cofactors scaled by the determinant's inverse.
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          m[j][i] = 5'(mod_alpha(grid_cofactor(k, i, j) * dinv));
    end
    for (int i = 0; i < 3; i++) begin
      res[i] = 0;
      for (int j = 0; j < 3; j++)
        res[i] += int'(m[i][j]) * v[j];
      res[i] = mod_alpha(res[i]);
    end
    r.out_a  = 5'(res[0]);
    r.out_b  = 5'(res[1]);
    r.out_c  = 5'(res[2]);
    r.status = STATUS_OK;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [4:0] got, input logic [4:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      key_copy = '0;
      pending_results.delete();
    end else begin
      if (blk_valid && !blk_stall) begin
        want = cipher_block(key_copy, blk_data);
        if (want.status == STATUS_NO_INVERSE)
          refused++;
        pending_results.insert(pending_results.size(), want);
      end
      if (res_valid && !res_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result transaction with no block waiting for it");
        end else begin
          want = pending_results.pop_front();
          check_field("out_a", res_data.out_a, want.out_a);
          check_field("out_b", res_data.out_b, want.out_b);
          check_field("out_c", res_data.out_c, want.out_c);
          check_field("status", 5'(res_data.status), 5'(want.status));
          checked++;
        end
      end
      if (psel && penable && pwrite && pready && paddr == KEY_ADDR)
        key_copy = pwdata[KEY_W-1:0];
    end
    outstanding <= pending_results.size();
  end

endmodule

[tb/hill_cipher_3x3_mod26_test.sv]
// Top of the Hill cipher testbench: clock, reset, key writes, block stimulus and verdict.
// Depends on hc_pkg, hc_tb_pkg, hill_cipher_3x3_mod26 and hill_cipher_3x3_mod26_checker.
module hill_cipher_3x3_mod26_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hc_pkg::*;
  import hc_tb_pkg::*;

  // This limit leaves a wide margin over the slowest correct run.
  localparam int LIMIT_CYCLES   = 200000;
  // Long enough for the letter pipeline to fill and push back on the block input.
  localparam int HOLD_CYCLES    = 80;
  // Covers the four-stage letter pipeline plus the settling of the key preparation.
  localparam int DRAIN_CYCLES   = 16;
  localparam int KEYS_PER_PHASE = 4;
  localparam int BLOCKS_PER_KEY = 100;
  localparam int SPARE_W        = PDATA_W - KEY_W;

  // Keys are written row-major with entry (0,0) in the low five bits, so each
  // literal lists row 2 first and column 2 first within a row.
  // The textbook key with rows 6 24 1 / 13 16 10 / 20 17 15; its determinant is 25.
  localparam logic [KEY_W-1:0] CLASSIC_KEY =
    {5'd15, 5'd17, 5'd20, 5'd10, 5'd16, 5'd13, 5'd1, 5'd24, 5'd6};
  // Every entry above 25: 27 on the diagonal and 26 elsewhere reduce to the identity.
  localparam logic [KEY_W-1:0] WRAPPED_IDENTITY =
    {5'd27, 5'd26, 5'd26, 5'd26, 5'd27, 5'd26, 5'd26, 5'd26, 5'd27};
  // Diagonal keys whose determinants, 2 and 13, each share a factor with 26.
  localparam logic [KEY_W-1:0] EVEN_DET_KEY =
    {5'd1, 5'd0, 5'd0, 5'd0, 5'd1, 5'd0, 5'd0, 5'd0, 5'd2};
  localparam logic [KEY_W-1:0] THIRTEEN_DET_KEY =
    {5'd1, 5'd0, 5'd0, 5'd0, 5'd1, 5'd0, 5'd0, 5'd0, 5'd13};
  // All ones: every entry reduces to 5, so the determinant is zero.
  localparam logic [KEY_W-1:0] ALL_ONES_KEY = '1;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               blk_valid = 1'b0;
  logic               blk_stall;
  in_item_t           blk_data  = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  out_item_t          res_data;

  // Idle and stall rates in percent, changed between phases by the stimulus.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // Raised by the stimulus, cleared by the receiver once the hold-off is over.
  bit long_hold      = 1'b0;
  int cycles         = 0;
  int key_writes     = 0;

  int fail_count;
  int outstanding;
  int checked;
  int refused;

  hill_cipher_3x3_mod26 dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .blk_valid (blk_valid),
    .blk_stall (blk_stall),
    .blk_data  (blk_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  hill_cipher_3x3_mod26_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .blk_valid   (blk_valid),
    .blk_stall   (blk_stall),
    .blk_data    (blk_data),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res_data    (res_data),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked),
    .refused     (refused)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Run stopped after %0d cycles with %0d results still due", cycles, outstanding);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side. Each cycle it stalls at the current rate; when a hold-off is
  // requested it stalls for HOLD_CYCLES straight, counting them here, while the
  // sender keeps offering blocks.
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Letters are mostly in the alphabet, but 26..31 also appear so that the
  // reduction of out-of-range letters is exercised.
  function automatic logic [LETTER_W-1:0] rand_letter();
    if ($urandom_range(99) < 80)
      return LETTER_W'($urandom_range(25));
    return LETTER_W'($urandom_range(31, 26));
  endfunction

  // Random raw key; when an invertible one is wanted, draw until the
  // determinant is a unit modulo 26 (roughly a third of all keys are).
  function automatic logic [KEY_W-1:0] rand_key(input bit need_unit);
    logic [KEY_W-1:0] k;
    do begin
      for (int i = 0; i < 9; i++)
        k[5*i +: 5] = 5'($urandom);
    end while (need_unit && unit_inverse(grid_det(unpack_key(k))) == 0);
    return k;
  endfunction

  // Every task below starts and ends right after a rising edge, and drives with
  // nonblocking assignments there.

  // Offer one block, after a random number of idle cycles, and hold it until
  // the block takes it. Valid is lowered only by an idle cycle, never in the
  // same step as it is raised again.
  task automatic send_block(input logic req, input logic [LETTER_W-1:0] a,
                            input logic [LETTER_W-1:0] b, input logic [LETTER_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      blk_valid <= 1'b0;
      @(posedge clk);
    end
    blk_valid <= 1'b1;
    blk_data  <= '{req_type: req, letter_a: a, letter_b: b, letter_c: c};
    do @(posedge clk); while (blk_stall);
  endtask

  // Stop offering, let every predicted result come back, then let the pipeline
  // and any key preparation settle. The first edge lets the scoreboard's count
  // catch up with the last accepted block.
  task automatic drain();
    blk_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write, setup phase then access phase, only with the block empty.
  // The unused upper bits of the data bus carry noise that the register has to drop.
  task automatic write_key(input logic [KEY_W-1:0] key);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KEY_ADDR;
    pwdata  <= {SPARE_W'($urandom), key};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    key_writes++;
  endtask

  // One random phase: several keys, most of them invertible so that the
  // multiply and inverse paths carry the bulk of the traffic. With squeeze
  // set, the first key of the phase starts with a long receiver hold-off.
  task automatic random_phase(input int send_pct, input int recv_pct, input bit squeeze);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int s = 0; s < KEYS_PER_PHASE; s++) begin
      write_key(rand_key(s != KEYS_PER_PHASE - 1));
      if (squeeze && s == 0)
        long_hold = 1'b1;
      for (int n = 0; n < BLOCKS_PER_KEY; n++)
        send_block(logic'($urandom_range(1)), rand_letter(), rand_letter(), rand_letter());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, no idling. The key after reset is all zero, so both
    // requests must come back refused.
    send_block(REQ_ENCRYPT, 5'd0, 5'd0, 5'd0);
    send_block(REQ_DECRYPT, 5'd25, 5'd25, 5'd25);

    // An invertible key: letter extremes, letters above 25, and a round trip
    // where ACT encrypts to POH and POH decrypts back to ACT.
    write_key(CLASSIC_KEY);
    send_block(REQ_ENCRYPT, 5'd0, 5'd0, 5'd0);
    send_block(REQ_ENCRYPT, 5'd25, 5'd25, 5'd25);
    send_block(REQ_DECRYPT, 5'd25, 5'd25, 5'd25);
    send_block(REQ_ENCRYPT, 5'd31, 5'd31, 5'd31);
    send_block(REQ_DECRYPT, 5'd26, 5'd30, 5'd31);
    send_block(REQ_ENCRYPT, 5'd0, 5'd2, 5'd19);
    send_block(REQ_DECRYPT, 5'd15, 5'd14, 5'd7);
    send_block(REQ_DECRYPT, 5'd7, 5'd4, 5'd11);

    // Key entries above 25 that reduce to the identity.
    write_key(WRAPPED_IDENTITY);
    send_block(REQ_ENCRYPT, 5'd1, 5'd2, 5'd3);
    send_block(REQ_DECRYPT, 5'd24, 5'd31, 5'd0);

    // Determinants that are not units: even, thirteen, and zero with the
    // register at its all-ones extreme.
    write_key(EVEN_DET_KEY);
    send_block(REQ_ENCRYPT, 5'd25, 5'd1, 5'd2);
    send_block(REQ_DECRYPT, 5'd3, 5'd4, 5'd5);
    write_key(THIRTEEN_DET_KEY);
    send_block(REQ_ENCRYPT, 5'd13, 5'd13, 5'd13);
    send_block(REQ_DECRYPT, 5'd0, 5'd25, 5'd13);
    write_key(ALL_ONES_KEY);
    send_block(REQ_ENCRYPT, 5'd31, 5'd31, 5'd31);
    send_block(REQ_DECRYPT, 5'd0, 5'd0, 5'd0);

    // Random part: receiver-heavy stalls, then sender-heavy gaps, then full
    // rate with one long hold-off to fill the pipeline.
    random_phase(30, 55, 1'b0);
    random_phase(55, 30, 1'b0);
    random_phase(0, 0, 1'b1);

    drain();
    $display("Checked %0d result transactions under %0d key writes; %0d were refused keys.",
             checked, key_writes, refused);
    $display("Idle mixes covered: sender-heavy, receiver-heavy, none, and one %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
